[hw/rtl/led_pattern_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Shared property forms for the sequencer checks.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Types, sizes and helpers shared by the LED pattern sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int DURATION_BITS = 32;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int DUR_W = DURATION_BITS;

  // Fixed item field widths
  localparam int REQ_W      = 2;
  localparam int IN_IDX_W   = 6;
  localparam int IN_LVL_W   = 8;
  localparam int IN_DUR_W   = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2
  } req_t;

  typedef struct packed {
    logic level;
    dur_t duration;
  } entry_t;

  typedef struct packed {
    logic active;
    logic led;
    idx_t position;
    idx_t pattern_start;
  } seq_state_t;

  localparam dur_t DUR_STOP = '1;

  // Input index reduced modulo the table depth (constant lookup).
  function automatic idx_t wrap_in(logic [IN_IDX_W-1:0] v);
    idx_t r;
    r = '0;
    for (int k = 0; k < (1 << IN_IDX_W); k++) begin
      if (v == IN_IDX_W'(k)) begin
        r = IDX_W'(k % TABLE_DEPTH);
      end
    end
    return r;
  endfunction

  function automatic idx_t next_idx(idx_t p);
    return (p == IDX_W'(TABLE_DEPTH - 1)) ? '0 : p + idx_t'(1);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lps_table.sv]
// ----------------------------------------------------------------------------
// lps_table
// Pattern table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lps_table (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire lps_pkg::idx_t   wr_idx,
  input  wire lps_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire lps_pkg::idx_t   rd_idx_a,
  input  wire lps_pkg::idx_t   rd_idx_b,
  output lps_pkg::entry_t      rd_a,
  output lps_pkg::entry_t      rd_b
);
  import lps_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_a_r;
  entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_idx_a];
      rd_b_r <= mem[rd_idx_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

[hw/rtl/lps_engine.sv]
// ----------------------------------------------------------------------------
// lps_engine
// Sequencer state and its update from one item plus the table read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lps_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire logic                s1_adv,
  input  wire lps_pkg::req_t       s1_req,
  input  wire lps_pkg::idx_t       s1_start,
  input  wire lps_pkg::entry_t     rd_a,
  input  wire lps_pkg::entry_t     rd_b,
  output lps_pkg::seq_state_t      state_r,
  output lps_pkg::seq_state_t      state_nxt
);
  import lps_pkg::*;

  seq_state_t st_r;
  seq_state_t st_nxt;
  dur_t       hold_r;
  dur_t       hold_nxt;

  always_comb begin
    st_nxt   = st_r;
    hold_nxt = hold_r;
    if (s1_valid) begin
      case (s1_req)
        REQ_TICK: begin
          if (hold_r != '0) begin
            hold_nxt = hold_r - dur_t'(1);
            if (hold_nxt == '0) begin
              if (!st_r.active) begin
                st_nxt.led = 1'b0;
              end else begin
                st_nxt.position = next_idx(st_r.position);
                if (rd_a.duration == DUR_STOP) begin
                  st_nxt.led    = rd_a.level;
                  st_nxt.active = 1'b0;
                  hold_nxt      = '0;
                end else if (rd_a.duration == '0) begin
                  // loop back: port B holds the start entry
                  st_nxt.led      = rd_b.level;
                  hold_nxt        = rd_b.duration;
                  st_nxt.position = next_idx(st_r.pattern_start);
                end else begin
                  st_nxt.led = rd_a.level;
                  hold_nxt   = rd_a.duration;
                end
              end
            end
          end
        end
        REQ_START: begin
          if (!(st_r.active && (st_r.pattern_start == s1_start))) begin
            st_nxt.active        = 1'b1;
            st_nxt.pattern_start = s1_start;
            st_nxt.led           = rd_a.level;
            st_nxt.position      = next_idx(s1_start);
            hold_nxt             = rd_a.duration;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      hold_r <= '0;
    end else if (s1_adv) begin
      st_r   <= st_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign state_r   = st_r;
  assign state_nxt = st_nxt;

endmodule

`default_nettype wire

[hw/rtl/led_pattern_sequencer_core.sv]
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// Plays a one-LED blink pattern from a (level, duration) table.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | dir | per item
//   --------+-----------------------------------------+-----+------------------
//   in      | in_valid/in_stall, in_req_type ...      | in  | tick/write/start
//   out     | out_valid/out_stall, out_led_on/playing | out | state after item
//
// An item is read from the table at its accept edge and its result enters
// the output register as stage 1 advances; an item can be accepted every cycle unless in_stall is high.
// Two read ports fetch the next entry and the pattern start in that one read.
// Reset (rst_n low, synchronous) clears sequencer state; the table is not
// cleared and holds garbage until written.
// in_stall is high only while a result waits under out_stall behind a read item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "led_pattern_sequencer_core_defines.svh"

module led_pattern_sequencer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lps_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [lps_pkg::IN_IDX_W-1:0]  in_entry_index,
  input  wire logic [lps_pkg::IN_LVL_W-1:0]  in_entry_level,
  input  wire logic [lps_pkg::IN_DUR_W-1:0]  in_entry_duration,
  input  wire logic [lps_pkg::IN_IDX_W-1:0]  in_start_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_led_on,
  output logic                               out_playing
);
  import lps_pkg::*;

  logic       in_accept;
  req_t       in_req;

  // Stage 1: item whose table data sits in the read registers
  logic       s1_valid_r;
  req_t       s1_req_r;
  idx_t       s1_start_r;
  logic       s1_adv;

  // Output register
  logic       out_valid_r;
  logic       out_led_on_r;
  logic       out_playing_r;

  entry_t     wr_data;
  idx_t       rd_idx_a;
  entry_t     rd_a;
  entry_t     rd_b;
  seq_state_t state_r;
  seq_state_t state_nxt;

  assign in_req    = req_t'(in_req_type);
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // An accepted item's reads see the state left by the item ahead of it:
  // state_nxt equals state_r whenever stage 1 is empty.
  assign rd_idx_a = (in_req == REQ_START) ? wrap_in(in_start_index) : state_nxt.position;

  assign wr_data.level    = (in_entry_level != '0);
  assign wr_data.duration = in_entry_duration[DUR_W-1:0];

  lps_table u_table (
    .clk      (clk),
    .wr_en    (in_accept && (in_req == REQ_WRITE)),
    .wr_idx   (wrap_in(in_entry_index)),
    .wr_data  (wr_data),
    .rd_en    (in_accept),
    .rd_idx_a (rd_idx_a),
    .rd_idx_b (state_nxt.pattern_start),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  lps_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_adv    (s1_adv),
    .s1_req    (s1_req_r),
    .s1_start  (s1_start_r),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .state_r   (state_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r   <= in_req;
      s1_start_r <= wrap_in(in_start_index);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_led_on_r  <= state_nxt.led;
      out_playing_r <= state_nxt.active;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_led_on  = out_led_on_r;
  assign out_playing = out_playing_r;

  // Checks
  `LPS_ASSERT_NXT(a_accept_fills_s1, clk, rst_n, in_accept, s1_valid_r,
                  "accepted item missing from stage 1")
  `LPS_ASSERT_NXT(a_start_plays, clk, rst_n, s1_adv && (s1_req_r == REQ_START),
                  out_valid_r && out_playing_r, "start item did not leave pattern playing")
  `LPS_ASSERT_IMP(a_stop_on_tick, clk, rst_n, $fell(state_r.active),
                  $past(s1_req_r == REQ_TICK), "pattern stopped by a non-tick item")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the LED pattern sequencer with table writes, pattern starts, ticks
// and the unused request code. A scoreboard class tracks the table and the
// play state, then checks each returned LED view in order. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lps_pkg::*;

  // Request code 3 is not part of the package enum; the block must ignore it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic led;
    logic playing;
  } led_view_t;

  // Tracks table contents and play state; one expected LED view per item.
  class led_seq_scoreboard;
    logic      lvl_tab [TABLE_DEPTH];
    dur_t      dur_tab [TABLE_DEPTH];
    dur_t      hold;
    idx_t      pos;
    idx_t      first;
    logic      active;
    logic      led;
    led_view_t expected_leds[$];
    int        errors;

    function new();
      hold   = '0;
      pos    = '0;
      first  = '0;
      active = 1'b0;
      led    = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction

    // One tick: count down, and on expiry take the entry at pos.
    function void advance_tick();
      logic nxt_lvl;
      dur_t nxt_dur;
      if (hold == '0) return;
      hold = hold - 1'b1;
      if (hold != '0) return;
      if (!active) begin
        led = 1'b0;
        return;
      end
      nxt_lvl = lvl_tab[pos];
      nxt_dur = dur_tab[pos];
      pos     = pos + 1'b1;
      if (nxt_dur == DUR_STOP) begin
        led    = nxt_lvl;
        hold   = '0;
        active = 1'b0;
      end else if (nxt_dur == '0) begin
        // loop back to the pattern's first entry
        led  = lvl_tab[first];
        hold = dur_tab[first];
        pos  = first + 1'b1;
      end else begin
        led  = nxt_lvl;
        hold = nxt_dur;
      end
    endfunction

    function void note_item(logic [REQ_W-1:0] req, logic [IN_IDX_W-1:0] eidx,
                            logic [IN_LVL_W-1:0] elvl, logic [IN_DUR_W-1:0] edur,
                            logic [IN_IDX_W-1:0] sidx);
      led_view_t view;
      case (req)
        REQ_TICK: begin
          advance_tick();
        end
        REQ_WRITE: begin
          lvl_tab[idx_t'(eidx)] = |elvl;
          dur_tab[idx_t'(eidx)] = dur_t'(edur);
        end
        REQ_START: begin
          // a start on the pattern already playing changes nothing
          if (!(active && first == idx_t'(sidx))) begin
            active = 1'b1;
            first  = idx_t'(sidx);
            led    = lvl_tab[first];
            hold   = dur_tab[first];
            pos    = first + 1'b1;
          end
        end
        default: ;
      endcase
      view.led     = led;
      view.playing = active;
      expected_leds.push_back(view);
    endfunction

    function void check_result(logic led_on, logic playing);
      led_view_t exp_view;
      if (expected_leds.size() == 0) begin
        $display("%0t: unexpected result led_on=%0b playing=%0b", $time, led_on, playing);
        errors++;
        return;
      end
      exp_view = expected_leds.pop_front();
      if (led_on !== exp_view.led) begin
        $display("%0t: led_on mismatch, expected %0b, actual %0b",
                 $time, exp_view.led, led_on);
        errors++;
      end
      if (playing !== exp_view.playing) begin
        $display("%0t: playing mismatch, expected %0b, actual %0b",
                 $time, exp_view.playing, playing);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type;
  logic [IN_IDX_W-1:0] in_entry_index;
  logic [IN_LVL_W-1:0] in_entry_level;
  logic [IN_DUR_W-1:0] in_entry_duration;
  logic [IN_IDX_W-1:0] in_start_index;
  logic                out_valid;
  logic                out_stall;
  logic                out_led_on;
  logic                out_playing;

  led_seq_scoreboard sb;
  int  items_sent;
  bit  in_idle_on;
  bit  out_idle_on;

  led_pattern_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_entry_level    (in_entry_level),
    .in_entry_duration (in_entry_duration),
    .in_start_index    (in_start_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_on        (out_led_on),
    .out_playing       (out_playing)
  );

  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Drive one item at a falling edge and hold it until accepted.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [IN_IDX_W-1:0] eidx,
                           input logic [IN_LVL_W-1:0] elvl,
                           input logic [IN_DUR_W-1:0] edur,
                           input logic [IN_IDX_W-1:0] sidx);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_entry_index    <= eidx;
    in_entry_level    <= elvl;
    in_entry_duration <= edur;
    in_start_index    <= sidx;
    do @(posedge clk); while (in_stall);
    sb.note_item(req, eidx, elvl, edur, sidx);
    items_sent++;
  endtask

  // Fields a request does not use still carry random values.
  task automatic do_tick();
    send_item(REQ_TICK, IN_IDX_W'($urandom()), IN_LVL_W'($urandom()), $urandom(),
              IN_IDX_W'($urandom()));
  endtask

  task automatic do_write(input int idx, input logic [IN_LVL_W-1:0] lvl,
                          input logic [IN_DUR_W-1:0] dur);
    send_item(REQ_WRITE, IN_IDX_W'(idx), lvl, dur, IN_IDX_W'($urandom()));
  endtask

  task automatic do_start(input int idx);
    send_item(REQ_START, IN_IDX_W'($urandom()), IN_LVL_W'($urandom()), $urandom(),
              IN_IDX_W'(idx));
  endtask

  task automatic do_unused();
    send_item(REQ_UNUSED, IN_IDX_W'($urandom()), IN_LVL_W'($urandom()), $urandom(),
              IN_IDX_W'($urandom()));
  endtask

  // Drop valid so the last item is not taken again, then let results drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_LVL_W-1:0] rand_level();
    return ($urandom_range(0, 2) == 0) ? '0 : IN_LVL_W'($urandom());
  endfunction

  // A short well-formed pattern: fill a run of entries, start it, tick it.
  task automatic play_random_pattern();
    int                  len;
    int                  base;
    int                  k;
    logic [IN_DUR_W-1:0] dur;
    len  = $urandom_range(1, 6);
    base = $urandom_range(0, TABLE_DEPTH - 1);
    for (k = 0; k < len; k++) begin
      dur = $urandom_range(1, 4);
      if (k == len - 1) begin
        case ($urandom_range(0, 3))
          0: dur = '0;
          1: dur = DUR_STOP;
          default: ;
        endcase
      end
      do_write(base + k, rand_level(), dur);
    end
    if ($urandom_range(0, 9) == 0) do_start($urandom_range(0, TABLE_DEPTH - 1));
    do_start(base);
    if ($urandom_range(0, 4) == 0) do_start(base);
    repeat ($urandom_range(4, 30)) begin
      case ($urandom_range(0, 19))
        0: do_unused();
        1: do_write($urandom_range(0, TABLE_DEPTH - 1), rand_level(), $urandom_range(1, 4));
        default: do_tick();
      endcase
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: do_write($urandom_range(0, TABLE_DEPTH - 1), IN_LVL_W'($urandom()), $urandom());
      1: do_start($urandom_range(0, TABLE_DEPTH - 1));
      2: do_unused();
      default: do_tick();
    endcase
  endtask

  // Result side: random stall before each result, check at acceptance.
  initial begin
    int stall_cycles;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall_cycles = out_idle_on ? $urandom_range(0, 16) : 0;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_led_on, out_playing);
    end
  end

  initial begin
    int  i;
    int  next_phase;
    bit  drained;
    sb                = new();
    items_sent        = 0;
    in_idle_on        = 1'b0;
    out_idle_on       = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    out_stall         = 1'b0;
    in_req_type       = REQ_TICK;
    in_entry_index    = '0;
    in_entry_level    = '0;
    in_entry_duration = '0;
    in_start_index    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The table is garbage after reset, so every entry is written first.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      do_write(i, rand_level(), $urandom_range(1, 3));
    end

    // Directed cases, idling on both sides.
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    do_write(0, 8'hFF, 32'd1);
    do_write(TABLE_DEPTH - 1, 8'h80, 32'd1);
    do_start(TABLE_DEPTH - 1);           // position wraps past the last entry
    do_tick();
    do_tick();
    do_start(TABLE_DEPTH - 1);           // same start while playing: ignored
    do_write(21, 8'h01, DUR_STOP);
    do_write(20, 8'h00, 32'd1);
    do_start(20);
    do_tick();                           // stop entry taken, pattern ends
    do_tick();
    do_start(21);                        // all-ones loaded as a hold time
    do_tick();
    do_write(30, 8'hFF, 32'd0);
    do_start(30);                        // zero hold: active but frozen
    do_tick();
    do_write(40, 8'h01, 32'd1);
    do_write(41, 8'h00, 32'd1);
    do_write(42, 8'hFE, 32'd0);
    do_start(40);
    do_tick();
    do_write(40, 8'h7F, 32'd0);          // loop lands on a zero-hold start
    do_tick();
    do_tick();
    do_write(5, 8'h00, 32'hFFFF_FFFE);
    do_unused();

    // Random part: mostly well-formed patterns, some noise.
    next_phase = items_sent;
    drained    = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= next_phase) begin
        in_idle_on  = $urandom_range(0, 2) != 0;
        out_idle_on = $urandom_range(0, 2) != 0;
        next_phase  = items_sent + PHASE_ITEMS;
      end
      if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
        wait_idle();
        drained = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) noise_item();
      else play_random_pattern();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/lps_table.sv
hw/rtl/lps_engine.sv
hw/rtl/led_pattern_sequencer_core.sv
test/testbench.sv
